[hdl/vsrt_pkg.sv]
package vsrt_pkg;

    localparam int TRIG_W      = 16;
    localparam int MAG_W       = TRIG_W - 1;
    localparam int ONE_Q14     = 16384;
    localparam int Q14_SHIFT   = 14;
    localparam int FINAL_SHIFT = 50;
    localparam int ANGLE_W     = 16;
    localparam int SCALE_W     = 16;
    localparam int OFFSET_W    = 16;
    localparam int CENTER_W    = 48;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 48;
    localparam int AXES        = 3;
    localparam int AXIS_W      = 2;

    localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Z = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER  = 3'd6;

    localparam logic signed [SCALE_W-1:0] SCALE_ONE = 16'sd256;

    typedef logic signed [TRIG_W-1:0] t_trig;

    typedef struct packed {
        logic mul;
        logic add;
    } t_rot_en;

endpackage

[hdl/vsrt_in_if.sv]
interface vsrt_in_if #(parameter int COORD_WIDTH = 16);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] vertex_x;
    logic signed [COORD_WIDTH-1:0] vertex_y;
    logic signed [COORD_WIDTH-1:0] vertex_z;

    modport source (output valid, output vertex_x, output vertex_y, output vertex_z,
                    input ready);
    modport sink   (input valid, input vertex_x, input vertex_y, input vertex_z,
                    output ready);
endinterface

[hdl/vsrt_out_if.sv]
interface vsrt_out_if #(parameter int COORD_WIDTH = 16);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] out_x;
    logic signed [COORD_WIDTH-1:0] out_y;
    logic signed [COORD_WIDTH-1:0] out_z;
    logic                          clipped;

    modport source (output valid, output out_x, output out_y, output out_z,
                    output clipped, input ready);
    modport sink   (input valid, input out_x, input out_y, input out_z,
                    input clipped, output ready);
endinterface

[hdl/vsrt_trig.sv]
module vsrt_trig #(
    parameter int TRIG_INDEX_BITS = 12
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_we,
    input  logic [vsrt_pkg::CFG_IDX_W-1:0]   i_idx,
    input  logic [vsrt_pkg::ANGLE_W-1:0]     i_angle,
    output vsrt_pkg::t_trig                  o_cos [vsrt_pkg::AXES],
    output vsrt_pkg::t_trig                  o_sin [vsrt_pkg::AXES],
    output logic                             o_busy
);
    import vsrt_pkg::*;

    localparam int  TIB     = TRIG_INDEX_BITS;
    localparam int  QUARTER = 1 << (TIB - 2);
    localparam int  AW      = TIB - 1;
    localparam real PI_HALF = 1.57079632679489661923;
    localparam real STEP    = PI_HALF / real'(QUARTER);

    typedef logic [MAG_W-1:0] t_rom [QUARTER+1];

    function automatic t_rom build_rom();
        t_rom rom;
        real  v;
        for (int r = 0; r <= QUARTER; r++) begin
            v = real'(ONE_Q14) * $sin(STEP * real'(r));
            rom[r] = MAG_W'($rtoi(v + 0.5));
        end
        return rom;
    endfunction

    localparam t_rom SIN_ROM = build_rom();

    // {negate, quarter-wave address}
    function automatic logic [AW:0] map_index(logic [TIB-1:0] k);
        logic [AW-1:0] r;
        logic [AW-1:0] addr;
        r    = AW'(k[TIB-3:0]);
        addr = k[TIB-2] ? (AW'(QUARTER) - r) : r;
        return {k[TIB-1], addr};
    endfunction

    logic            angle_we;
    logic [TIB-1:0]  k_sin;
    logic [TIB-1:0]  k_cos;
    logic [AW:0]     map_s;
    logic [AW:0]     map_c;

    logic              r_p1_v;
    logic [AXIS_W-1:0] r_p1_axis;
    logic [AW-1:0]     r_addr_s;
    logic [AW-1:0]     r_addr_c;
    logic              r_neg1_s;
    logic              r_neg1_c;

    logic              r_p2_v;
    logic [AXIS_W-1:0] r_p2_axis;
    logic [MAG_W-1:0]  r_rd_s;
    logic [MAG_W-1:0]  r_rd_c;
    logic              r_neg2_s;
    logic              r_neg2_c;

    t_trig r_cos [AXES];
    t_trig r_sin [AXES];
    t_trig mag_s;
    t_trig mag_c;

    assign angle_we = i_we && (i_idx == REG_ANGLE_X || i_idx == REG_ANGLE_Y ||
                               i_idx == REG_ANGLE_Z);
    assign k_sin    = i_angle[ANGLE_W-1 -: TIB];
    assign k_cos    = k_sin + TIB'(QUARTER);
    assign map_s    = map_index(k_sin);
    assign map_c    = map_index(k_cos);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
            r_p2_v <= 1'b0;
        end else begin
            r_p1_v <= angle_we;
            r_p2_v <= r_p1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_axis <= i_idx[AXIS_W-1:0];
        r_addr_s  <= map_s[AW-1:0];
        r_addr_c  <= map_c[AW-1:0];
        r_neg1_s  <= map_s[AW];
        r_neg1_c  <= map_c[AW];
        r_p2_axis <= r_p1_axis;
        r_rd_s    <= SIN_ROM[r_addr_s];
        r_rd_c    <= SIN_ROM[r_addr_c];
        r_neg2_s  <= r_neg1_s;
        r_neg2_c  <= r_neg1_c;
    end

    assign mag_s = t_trig'({1'b0, r_rd_s});
    assign mag_c = t_trig'({1'b0, r_rd_c});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < AXES; a++) begin
                r_cos[a] <= t_trig'(ONE_Q14);
                r_sin[a] <= '0;
            end
        end else if (r_p2_v) begin
            for (int a = 0; a < AXES; a++) begin
                if (r_p2_axis == AXIS_W'(a)) begin
                    r_cos[a] <= r_neg2_c ? -mag_c : mag_c;
                    r_sin[a] <= r_neg2_s ? -mag_s : mag_s;
                end
            end
        end
    end

    assign o_cos  = r_cos;
    assign o_sin  = r_sin;
    assign o_busy = r_p1_v || r_p2_v;

    a_busy_after_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        angle_we |=> o_busy)
        else $error("trig lookup not started after angle write");

    a_p2_follows_p1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p2_v |-> $past(r_p1_v))
        else $error("ROM data stage without address stage");

    for (genvar a = 0; a < AXES; a++) begin : g_bound
        a_trig_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            r_cos[a] <= ONE_Q14 && r_cos[a] >= -ONE_Q14 &&
            r_sin[a] <= ONE_Q14 && r_sin[a] >= -ONE_Q14)
            else $error("trig cache value out of range");
    end

endmodule

[hdl/vsrt_rotate.sv]
module vsrt_rotate #(
    parameter int IN_W = 32
) (
    input  logic                                        i_clk,
    input  vsrt_pkg::t_rot_en                           i_en,
    input  vsrt_pkg::t_trig                             i_cos,
    input  vsrt_pkg::t_trig                             i_sin,
    input  logic signed [IN_W-1:0]                      i_a,
    input  logic signed [IN_W-1:0]                      i_b,
    input  logic signed [IN_W-1:0]                      i_p,
    output logic signed [IN_W+vsrt_pkg::TRIG_W-1:0]     o_a,
    output logic signed [IN_W+vsrt_pkg::TRIG_W-1:0]     o_b,
    output logic signed [IN_W+vsrt_pkg::TRIG_W-1:0]     o_p
);
    import vsrt_pkg::*;

    localparam int OUT_W = IN_W + TRIG_W;

    // a' = a*cos - b*sin, b' = a*sin + b*cos, p' = p scaled by one
    logic signed [OUT_W-1:0] r_ac;
    logic signed [OUT_W-1:0] r_bs;
    logic signed [OUT_W-1:0] r_as;
    logic signed [OUT_W-1:0] r_bc;
    logic signed [OUT_W-1:0] r_p;
    logic signed [OUT_W-1:0] r_oa;
    logic signed [OUT_W-1:0] r_ob;
    logic signed [OUT_W-1:0] r_op;

    always_ff @(posedge i_clk) begin
        if (i_en.mul) begin
            r_ac <= OUT_W'(i_a) * OUT_W'(i_cos);
            r_bs <= OUT_W'(i_b) * OUT_W'(i_sin);
            r_as <= OUT_W'(i_a) * OUT_W'(i_sin);
            r_bc <= OUT_W'(i_b) * OUT_W'(i_cos);
            r_p  <= OUT_W'(i_p) <<< Q14_SHIFT;
        end
        if (i_en.add) begin
            r_oa <= r_ac - r_bs;
            r_ob <= r_as + r_bc;
            r_op <= r_p;
        end
    end

    assign o_a = r_oa;
    assign o_b = r_ob;
    assign o_p = r_op;

endmodule

[hdl/vsrt_round.sv]
module vsrt_round #(
    parameter int COORD_W = 16,
    parameter int SUM_W   = 82
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic signed [SUM_W-1:0]   i_sum,
    output logic signed [COORD_W-1:0] o_q,
    output logic                      o_clip
);
    import vsrt_pkg::*;

    localparam int TOP_LSB = FINAL_SHIFT + COORD_W - 1;
    localparam logic signed [COORD_W-1:0] Q_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] Q_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    logic [SUM_W-TOP_LSB-1:0] top_bits;
    logic                     in_range;
    logic signed [COORD_W-1:0] n_q;

    logic signed [COORD_W-1:0] r_q;
    logic                      r_clip;

    // sum already carries the rounding half
    assign top_bits = i_sum[SUM_W-1:TOP_LSB];
    assign in_range = (&top_bits) || !(|top_bits);

    always_comb begin
        if (in_range) begin
            n_q = i_sum[FINAL_SHIFT +: COORD_W];
        end else if (i_sum[SUM_W-1]) begin
            n_q = Q_MIN;
        end else begin
            n_q = Q_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q    <= n_q;
            r_clip <= !in_range;
        end
    end

    assign o_q    = r_q;
    assign o_clip = r_clip;

endmodule

[hdl/vertex_scale_rotate_translate.sv]
// Throughput: one vertex per cycle through the nine-stage multiply/add
// pipeline while the output is not stalled and input is not held off.
// Any config write holds off input in the cycle of the write; an angle write
// also holds it off while the quarter-wave sine ROM is read into the trig cache.
// Reset (i_rst_n low, synchronous): pipeline empty, scales 1.0, center 0,
// trig cache cos 1.0 and sin 0.
module vertex_scale_rotate_translate #(
    parameter int COORD_WIDTH     = 16,
    parameter int TRIG_INDEX_BITS = 12
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    vsrt_in_if.sink                           i_in,
    vsrt_out_if.source                        o_out,
    input  logic                              i_cfg_we,
    input  logic [vsrt_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [vsrt_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import vsrt_pkg::*;

    localparam int W1    = COORD_WIDTH + SCALE_W;
    localparam int W2    = W1 + TRIG_W;
    localparam int W3    = W2 + TRIG_W;
    localparam int W4    = W3 + TRIG_W;
    localparam int SUM_W = W4 + 2;

    localparam int ST_SCALE  = 0;
    localparam int ST_RX_MUL = 1;
    localparam int ST_RX_ADD = 2;
    localparam int ST_RY_MUL = 3;
    localparam int ST_RY_ADD = 4;
    localparam int ST_RZ_MUL = 5;
    localparam int ST_RZ_ADD = 6;
    localparam int ST_CENTER = 7;
    localparam int ST_OUT    = 8;
    localparam int NS        = 9;

    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (FINAL_SHIFT - 1);
    localparam logic signed [COORD_WIDTH-1:0] Q_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] Q_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    logic signed [SCALE_W-1:0]  r_scale [AXES];
    logic [CENTER_W-1:0]        r_center;
    logic [NS-1:0]              r_v;
    logic [NS-1:0]              en;
    logic                       trig_busy;
    logic                       accept;

    t_trig trig_cos [AXES];
    t_trig trig_sin [AXES];

    logic signed [OFFSET_W-1:0] cx;
    logic signed [OFFSET_W-1:0] cy;
    logic signed [OFFSET_W-1:0] cz;

    logic signed [W1-1:0] r_x0;
    logic signed [W1-1:0] r_y0;
    logic signed [W1-1:0] r_z0;
    logic signed [W2-1:0] x1, y1, z1;
    logic signed [W3-1:0] x2, y2, z2;
    logic signed [W4-1:0] x3, y3, z3;
    logic signed [SUM_W-1:0] r_sx;
    logic signed [SUM_W-1:0] r_sy;
    logic signed [SUM_W-1:0] r_sz;

    logic clip_x, clip_y, clip_z;

    // config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < AXES; a++) begin
                r_scale[a] <= SCALE_ONE;
            end
            r_center <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SCALE_X: r_scale[AXIS_X] <= i_cfg_data[SCALE_W-1:0];
                REG_SCALE_Y: r_scale[AXIS_Y] <= i_cfg_data[SCALE_W-1:0];
                REG_SCALE_Z: r_scale[AXIS_Z] <= i_cfg_data[SCALE_W-1:0];
                REG_CENTER:  r_center        <= i_cfg_data[CENTER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    vsrt_trig #(
        .TRIG_INDEX_BITS(TRIG_INDEX_BITS)
    ) u_trig (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_angle (i_cfg_data[ANGLE_W-1:0]),
        .o_cos   (trig_cos),
        .o_sin   (trig_sin),
        .o_busy  (trig_busy)
    );

    // stage enables: a stage loads when empty or when the next one moves
    always_comb begin
        en[NS-1] = !r_v[NS-1] || o_out.ready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign i_in.ready = en[ST_SCALE] && !trig_busy && !i_cfg_we;
    assign accept     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[ST_SCALE]) begin
                r_v[ST_SCALE] <= accept;
            end
            for (int k = 1; k < NS; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_SCALE]) begin
            r_x0 <= W1'(i_in.vertex_x) * W1'(r_scale[AXIS_X]);
            r_y0 <= W1'(i_in.vertex_y) * W1'(r_scale[AXIS_Y]);
            r_z0 <= W1'(i_in.vertex_z) * W1'(r_scale[AXIS_Z]);
        end
    end

    // about X: (y, z) rotate, x passes
    vsrt_rotate #(.IN_W(W1)) u_rot_x (
        .i_clk (i_clk),
        .i_en  ('{mul: en[ST_RX_MUL], add: en[ST_RX_ADD]}),
        .i_cos (trig_cos[AXIS_X]),
        .i_sin (trig_sin[AXIS_X]),
        .i_a   (r_y0),
        .i_b   (r_z0),
        .i_p   (r_x0),
        .o_a   (y1),
        .o_b   (z1),
        .o_p   (x1)
    );

    // about Y: (z, x) rotate, y passes
    vsrt_rotate #(.IN_W(W2)) u_rot_y (
        .i_clk (i_clk),
        .i_en  ('{mul: en[ST_RY_MUL], add: en[ST_RY_ADD]}),
        .i_cos (trig_cos[AXIS_Y]),
        .i_sin (trig_sin[AXIS_Y]),
        .i_a   (z1),
        .i_b   (x1),
        .i_p   (y1),
        .o_a   (z2),
        .o_b   (x2),
        .o_p   (y2)
    );

    // about Z: (x, y) rotate, z passes
    vsrt_rotate #(.IN_W(W3)) u_rot_z (
        .i_clk (i_clk),
        .i_en  ('{mul: en[ST_RZ_MUL], add: en[ST_RZ_ADD]}),
        .i_cos (trig_cos[AXIS_Z]),
        .i_sin (trig_sin[AXIS_Z]),
        .i_a   (x2),
        .i_b   (y2),
        .i_p   (z2),
        .o_a   (x3),
        .o_b   (y3),
        .o_p   (z3)
    );

    assign cx = r_center[OFFSET_W-1:0];
    assign cy = r_center[2*OFFSET_W-1:OFFSET_W];
    assign cz = r_center[3*OFFSET_W-1:2*OFFSET_W];

    // center offset and rounding half in one add
    always_ff @(posedge i_clk) begin
        if (en[ST_CENTER]) begin
            r_sx <= SUM_W'(x3) + (SUM_W'(cx) <<< FINAL_SHIFT) + ROUND_HALF;
            r_sy <= SUM_W'(y3) + (SUM_W'(cy) <<< FINAL_SHIFT) + ROUND_HALF;
            r_sz <= SUM_W'(z3) + (SUM_W'(cz) <<< FINAL_SHIFT) + ROUND_HALF;
        end
    end

    vsrt_round #(.COORD_W(COORD_WIDTH), .SUM_W(SUM_W)) u_round_x (
        .i_clk  (i_clk),
        .i_en   (en[ST_OUT]),
        .i_sum  (r_sx),
        .o_q    (o_out.out_x),
        .o_clip (clip_x)
    );

    vsrt_round #(.COORD_W(COORD_WIDTH), .SUM_W(SUM_W)) u_round_y (
        .i_clk  (i_clk),
        .i_en   (en[ST_OUT]),
        .i_sum  (r_sy),
        .o_q    (o_out.out_y),
        .o_clip (clip_y)
    );

    vsrt_round #(.COORD_W(COORD_WIDTH), .SUM_W(SUM_W)) u_round_z (
        .i_clk  (i_clk),
        .i_en   (en[ST_OUT]),
        .i_sum  (r_sz),
        .o_q    (o_out.out_z),
        .o_clip (clip_z)
    );

    assign o_out.valid   = r_v[ST_OUT];
    assign o_out.clipped = clip_x || clip_y || clip_z;

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> $past(r_v[ST_CENTER]) || $past(o_out.valid))
        else $error("result appeared without an item in the center stage");

    a_clip_extreme: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.clipped |->
            o_out.out_x == Q_MAX || o_out.out_x == Q_MIN ||
            o_out.out_y == Q_MAX || o_out.out_y == Q_MIN ||
            o_out.out_z == Q_MAX || o_out.out_z == Q_MIN)
        else $error("clipped set without a saturated coordinate");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=>
            o_out.valid && $stable(o_out.out_x) && $stable(o_out.out_y) &&
            $stable(o_out.out_z) && $stable(o_out.clipped))
        else $error("stalled result changed before its transfer");

endmodule
